/* design/hbsr_pkg.sv */
// shared constants of the h-bridge speed ramp generator
package hbsr_pkg;

  // number of equal ramp steps; must be a power of two so the step is a shift
  localparam int RampSteps = 16;
  localparam int RampShift = $clog2(RampSteps);
  localparam int StepsW    = $clog2(RampSteps + 1);

  localparam int ModeW   = 3;
  localparam int SpeedW  = 16;
  localparam int DutyW   = 15;
  localparam int TicksW  = 16;
  localparam int CurW    = 24;
  localparam int DiffW   = CurW + 1;
  localparam int InDataW = 24;
  localparam int OutDataW = 32;

  localparam logic [TicksW-1:0] StepWaitRst     = 16'd1000;
  localparam logic [TicksW-1:0] ReversalWaitRst = 16'd100;

  // register indexes of the configuration port
  localparam logic CfgStepWait     = 1'b0;
  localparam logic CfgReversalWait = 1'b1;

  // command codes
  localparam logic [ModeW-1:0] ModeTick     = 3'd0;
  localparam logic [ModeW-1:0] ModeSet      = 3'd1;
  localparam logic [ModeW-1:0] ModeRampSet  = 3'd2;
  localparam logic [ModeW-1:0] ModeStop     = 3'd3;
  localparam logic [ModeW-1:0] ModeRampStop = 3'd4;

endpackage

/* design/hbridge_speed_ramp_top.sv */
// h-bridge speed ramp generator: command stream in, duty stream out
//
// Each input transaction is one clock tick of the ramp controller. tuser carries the
// command (tick, instant set, ramp set, instant stop, ramp stop) and tdata the signed
// Q1.15 target speed. Every input transaction yields exactly one output transaction with
// the two H-bridge duty values, a busy flag and a rejected flag.
// The state update is done in the cycle of acceptance and the result is registered, so
// the result appears in the cycle after acceptance, and one transaction per cycle is
// sustained while the receiver is ready. The output register is the only buffer:
// s_axis_tready follows m_axis_tready while a result is pending, so a stalled receiver
// holds the result and stops input until the result is taken.
// Ramps and reversal waits count input transactions, not clock cycles: step_wait_ticks
// and reversal_wait_ticks (configuration registers 0 and 1) give the number of ticks.
// Configuration writes take effect at the next edge; write only while idle.
// Reset (rst_ni low, asynchronous) clears the speed to zero, the controller to idle,
// the output register to empty and the wait registers to 1000 and 100 ticks.
module hbridge_speed_ramp_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [15:0] speed, [23:16] zero
  input  logic [2:0]  s_axis_tuser,   // [2:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [14:0] duty_a, [29:15] duty_b, [30] busy_res,
                                      // [31] rejected
);

  typedef enum logic [1:0] {
    PhIdle    = 2'd0,
    PhRevWait = 2'd1,
    PhRamp    = 2'd2
  } phase_e;

  phase_e phase_q, phase_d;
  logic signed [hbsr_pkg::CurW-1:0]   cur_q, cur_d;
  logic signed [hbsr_pkg::CurW-1:0]   step_q, step_d;
  logic signed [hbsr_pkg::SpeedW-1:0] tgt_q, tgt_d;
  logic [hbsr_pkg::StepsW-1:0]        steps_q, steps_d;
  logic [hbsr_pkg::TicksW-1:0]        wait_q, wait_d;
  logic                               raw_q, raw_d;
  logic [hbsr_pkg::TicksW-1:0]        step_wait_q, rev_wait_q;
  logic                               out_valid_q;
  logic [hbsr_pkg::OutDataW-1:0]      out_data_q, out_data_d;

  logic                               s_acc;
  logic [hbsr_pkg::ModeW-1:0]         mode;
  logic signed [hbsr_pkg::SpeedW-1:0] spd;
  logic                               is_cmd;
  logic                               reverse;
  logic                               start_ramp;
  logic                               rej;
  logic signed [hbsr_pkg::DiffW-1:0]  diff;
  logic signed [hbsr_pkg::DiffW-1:0]  diff_adj;
  logic signed [hbsr_pkg::DiffW-1:0]  quot;
  logic [hbsr_pkg::CurW-1:0]          mag_full;
  logic [hbsr_pkg::DutyW-1:0]         mag;
  logic [hbsr_pkg::DutyW-1:0]         duty_a, duty_b;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign mode = s_axis_tuser;
  // -32768 saturates to -32767
  assign spd  = (s_axis_tdata[15:0] == 16'h8000) ? 16'sh8001 : $signed(s_axis_tdata[15:0]);

  assign is_cmd = (mode == hbsr_pkg::ModeSet) || (mode == hbsr_pkg::ModeRampSet) ||
                  (mode == hbsr_pkg::ModeStop) || (mode == hbsr_pkg::ModeRampStop);

  // zero counts as backward, so setting zero from a positive speed reverses through the wait
  assign reverse = (spd > 0) ? cur_q[hbsr_pkg::CurW-1]
                             : ((cur_q != '0) && !cur_q[hbsr_pkg::CurW-1]);

  always_comb begin
    cur_d      = cur_q;
    step_d     = step_q;
    tgt_d      = tgt_q;
    steps_d    = steps_q;
    wait_d     = wait_q;
    phase_d    = phase_q;
    raw_d      = raw_q;
    rej        = 1'b0;
    start_ramp = 1'b0;
    diff       = '0;
    diff_adj   = '0;
    quot       = '0;

    if (!is_cmd || phase_q != PhIdle) begin
      rej = is_cmd;
      if (phase_q != PhIdle) begin
        if (wait_q != '0) begin
          wait_d = wait_q - 1'b1;
        end else if (phase_q == PhRevWait) begin
          if (raw_q) begin
            start_ramp = 1'b1;
          end else begin
            cur_d   = {tgt_q, 8'b0};
            phase_d = PhIdle;
          end
        end else begin
          steps_d = steps_q - 1'b1;
          if (steps_q == hbsr_pkg::StepsW'(1)) begin
            // last step lands on the target exactly
            cur_d   = {tgt_q, 8'b0};
            phase_d = PhIdle;
          end else begin
            cur_d  = cur_q + step_q;
            wait_d = step_wait_q;
          end
        end
      end
    end else begin
      case (mode)
        hbsr_pkg::ModeSet, hbsr_pkg::ModeRampSet: begin
          tgt_d = spd;
          if (reverse) begin
            cur_d   = '0;
            wait_d  = rev_wait_q;
            raw_d   = (mode == hbsr_pkg::ModeRampSet);
            phase_d = PhRevWait;
          end else if (mode == hbsr_pkg::ModeRampSet) begin
            start_ramp = 1'b1;
          end else begin
            cur_d = {spd, 8'b0};
          end
        end
        hbsr_pkg::ModeStop: begin
          cur_d = '0;
          tgt_d = '0;
        end
        hbsr_pkg::ModeRampStop: begin
          tgt_d      = '0;
          start_ramp = 1'b1;
        end
        default: begin
        end
      endcase
    end

    if (start_ramp) begin
      diff     = $signed({tgt_d[hbsr_pkg::SpeedW-1], tgt_d, 8'b0}) -
                 $signed({cur_q[hbsr_pkg::CurW-1], cur_q});
      // bias negative values so the shift truncates toward zero
      diff_adj = diff + (diff[hbsr_pkg::DiffW-1] ? hbsr_pkg::DiffW'(hbsr_pkg::RampSteps - 1)
                                                  : hbsr_pkg::DiffW'(0));
      quot     = diff_adj >>> hbsr_pkg::RampShift;
      step_d   = quot[hbsr_pkg::CurW-1:0];
      steps_d  = hbsr_pkg::StepsW'(hbsr_pkg::RampSteps);
      wait_d   = step_wait_q;
      phase_d  = PhRamp;
    end
  end

  assign mag_full = cur_d[hbsr_pkg::CurW-1] ? (-cur_d) : cur_d;
  assign mag      = mag_full[22:8];
  assign duty_a   = cur_d[hbsr_pkg::CurW-1] ? mag : '0;
  assign duty_b   = (!cur_d[hbsr_pkg::CurW-1] && cur_d != '0) ? mag : '0;
  assign out_data_d = {rej, (phase_d != PhIdle), duty_b, duty_a};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      cur_q       <= '0;
      step_q      <= '0;
      tgt_q       <= '0;
      steps_q     <= '0;
      wait_q      <= '0;
      raw_q       <= 1'b0;
      step_wait_q <= hbsr_pkg::StepWaitRst;
      rev_wait_q  <= hbsr_pkg::ReversalWaitRst;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == hbsr_pkg::CfgStepWait) begin
          step_wait_q <= cfg_data_i;
        end else begin
          rev_wait_q <= cfg_data_i;
        end
      end
      if (s_acc) begin
        phase_q     <= phase_d;
        cur_q       <= cur_d;
        step_q      <= step_d;
        tgt_q       <= tgt_d;
        steps_q     <= steps_d;
        wait_q      <= wait_d;
        raw_q       <= raw_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      out_data_q <= out_data_d;
    end
  end

  // only one bridge side may be driven at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[14:0] == '0 || m_axis_tdata[29:15] == '0))
    else $error("both duty channels nonzero");

  // a ramp always has between one and RampSteps steps to go
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhRamp |->
      (steps_q != '0 && steps_q <= hbsr_pkg::StepsW'(hbsr_pkg::RampSteps)))
    else $error("ramp step count out of range");

  // the busy flag of a result matches the controller phase after the update
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (m_axis_tdata[30] == (phase_q != PhIdle)))
    else $error("busy flag disagrees with phase");

  // a command is never rejected while the controller is idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && phase_q == PhIdle) |=> !m_axis_tdata[31])
    else $error("command rejected while idle");

endmodule
